// ----- design/usv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_pkg: shared types and constants
// byte classes, queue entry layout, register indexes and code point limits
// ----------------------------------------------------------------------------
package usv_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned COUNT_W     = 21;
    localparam int unsigned CP_W        = 21;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 21;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BYTES  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REJECT_NUL = 4'd1;

    localparam logic [COUNT_W-1:0] MAX_BYTES_RST  = 21'd1048576;
    localparam logic               REJECT_NUL_RST = 1'b1;

    // byte classification thresholds
    localparam logic [DATA_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [DATA_W-1:0] LEAD2_MIN  = 8'hC2;
    localparam logic [DATA_W-1:0] LEAD2_MAX  = 8'hDF;
    localparam logic [DATA_W-1:0] LEAD3_MIN  = 8'hE0;
    localparam logic [DATA_W-1:0] LEAD3_MAX  = 8'hEF;
    localparam logic [DATA_W-1:0] LEAD4_MIN  = 8'hF0;
    localparam logic [DATA_W-1:0] LEAD4_MAX  = 8'hF4;
    localparam logic [DATA_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [DATA_W-1:0] CONT_TAG   = 8'h80;

    // code point limits
    localparam logic [CP_W-1:0] CP_MIN2      = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN3      = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4      = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    // continuation counts of an open sequence
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_BAD
    } byte_kind_t;

    // one classified byte as it waits in the queue
    typedef struct packed {
        byte_kind_t kind;
        logic [5:0] payload;   // masked value bits of the byte
        logic       nul_err;   // zero byte while nul is rejected
        logic       last;
    } item_t;

endpackage

// ----- design/usv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_front: byte classifier
// sorts an incoming byte into ascii, lead, continuation or bad and masks its bits
// ----------------------------------------------------------------------------
module usv_front
(
    input  logic [usv_pkg::DATA_W-1:0] data_byte,
    input  logic                       last_byte,
    input  logic                       reject_nul,
    output usv_pkg::item_t             item
);

    always_comb
    begin
        item.last    = last_byte;
        item.nul_err = reject_nul && (data_byte == '0);
        item.payload = data_byte[5:0];
        if (data_byte <= usv_pkg::ASCII_MAX)
        begin
            item.kind = usv_pkg::KIND_ASCII;
        end
        else if ((data_byte & usv_pkg::CONT_MASK) == usv_pkg::CONT_TAG)
        begin
            item.kind = usv_pkg::KIND_CONT;
        end
        else if (data_byte >= usv_pkg::LEAD2_MIN && data_byte <= usv_pkg::LEAD2_MAX)
        begin
            item.kind    = usv_pkg::KIND_LEAD2;
            item.payload = {1'b0, data_byte[4:0]};
        end
        else if (data_byte >= usv_pkg::LEAD3_MIN && data_byte <= usv_pkg::LEAD3_MAX)
        begin
            item.kind    = usv_pkg::KIND_LEAD3;
            item.payload = {2'b00, data_byte[3:0]};
        end
        else if (data_byte >= usv_pkg::LEAD4_MIN && data_byte <= usv_pkg::LEAD4_MAX)
        begin
            item.kind    = usv_pkg::KIND_LEAD4;
            item.payload = {3'b000, data_byte[2:0]};
        end
        else
        begin
            item.kind = usv_pkg::KIND_BAD;
        end
    end

endmodule

// ----- design/usv_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_queue: classified byte queue
// small register fifo between the classifier and the decoder
// ----------------------------------------------------------------------------
module usv_queue
#(
    parameter int unsigned DEPTH = usv_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  usv_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output usv_pkg::item_t head_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    usv_pkg::item_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/usv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_back: sequence decoder
// tracks open sequences, length limit and sticky error, registers the verdict
// ----------------------------------------------------------------------------
module usv_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  usv_pkg::item_t                  head_item,
    output logic                            pop,
    input  logic [usv_pkg::COUNT_W-1:0]     max_bytes,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic                            res_is_valid,
    output logic [usv_pkg::COUNT_W-1:0]     res_byte_count
);

    logic [1:0]                  pending_reg, pending_next;
    logic [1:0]                  seq_len_reg, seq_len_next;
    logic [usv_pkg::CP_W-1:0]    acc_reg, acc_next;
    logic                        err_reg, err_next;
    logic [usv_pkg::COUNT_W-1:0] seen_reg, seen_next;
    logic                        res_valid_reg, res_valid_next;
    logic                        res_ok_reg;
    logic [usv_pkg::COUNT_W-1:0] res_count_reg;
    logic [usv_pkg::COUNT_W:0]   count_inc;
    logic [usv_pkg::CP_W-1:0]    cp_full;
    logic                        cp_bad;

    // verdict of the string including the byte just decoded
    function automatic logic err_next_pre_clear(
        input logic                        err_in,
        input usv_pkg::item_t              it,
        input logic [1:0]                  pend,
        input logic [usv_pkg::COUNT_W:0]   cnt,
        input logic [usv_pkg::COUNT_W-1:0] limit,
        input logic                        bad_cp
    );
        logic e;
        e = err_in || it.nul_err || (cnt > {1'b0, limit});
        if (pend == '0)
        begin
            // a lead byte as last leaves the sequence cut off
            e = e || (it.kind != usv_pkg::KIND_ASCII);
        end
        else if (it.kind != usv_pkg::KIND_CONT)
        begin
            e = 1'b1;
        end
        else
        begin
            e = e || (pend != 2'd1) || bad_cp;
        end
        return e;
    endfunction

    // a last byte waits until the result slot is free or being emptied
    assign pop = head_valid && (!head_item.last || !res_valid_reg || res_ready);

    assign count_inc = {1'b0, seen_reg} + 1'b1;
    assign cp_full   = {acc_reg[usv_pkg::CP_W-7:0], head_item.payload};

    always_comb
    begin
        cp_bad = (cp_full >= usv_pkg::CP_SURR_LO && cp_full <= usv_pkg::CP_SURR_HI)
              || (cp_full > usv_pkg::CP_MAX);
        case (seq_len_reg)
            usv_pkg::SEQ_TWO:   cp_bad = cp_bad || (cp_full < usv_pkg::CP_MIN2);
            usv_pkg::SEQ_THREE: cp_bad = cp_bad || (cp_full < usv_pkg::CP_MIN3);
            usv_pkg::SEQ_FOUR:  cp_bad = cp_bad || (cp_full < usv_pkg::CP_MIN4);
            default:            cp_bad = cp_bad;
        endcase
    end

    always_comb
    begin
        pending_next   = pending_reg;
        seq_len_next   = seq_len_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        seen_next      = seen_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (pop)
        begin
            // length limit with saturation
            if (count_inc > {1'b0, max_bytes})
            begin
                err_next  = 1'b1;
                seen_next = max_bytes;
            end
            else
            begin
                seen_next = count_inc[usv_pkg::COUNT_W-1:0];
            end

            if (head_item.nul_err)
            begin
                err_next = 1'b1;
            end

            if (pending_reg == '0)
            begin
                case (head_item.kind)
                    usv_pkg::KIND_ASCII:
                    begin
                    end
                    usv_pkg::KIND_LEAD2:
                    begin
                        pending_next = 2'd1;
                        seq_len_next = usv_pkg::SEQ_TWO;
                        acc_next     = usv_pkg::CP_W'(head_item.payload);
                    end
                    usv_pkg::KIND_LEAD3:
                    begin
                        pending_next = 2'd2;
                        seq_len_next = usv_pkg::SEQ_THREE;
                        acc_next     = usv_pkg::CP_W'(head_item.payload);
                    end
                    usv_pkg::KIND_LEAD4:
                    begin
                        pending_next = 2'd3;
                        seq_len_next = usv_pkg::SEQ_FOUR;
                        acc_next     = usv_pkg::CP_W'(head_item.payload);
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            else if (head_item.kind != usv_pkg::KIND_CONT)
            begin
                // broken sequence: drop it, byte is not re-decoded
                err_next     = 1'b1;
                pending_next = '0;
                seq_len_next = usv_pkg::SEQ_NONE;
                acc_next     = '0;
            end
            else
            begin
                pending_next = pending_reg - 1'b1;
                acc_next     = cp_full;
                if (pending_reg == 2'd1)
                begin
                    if (cp_bad)
                    begin
                        err_next = 1'b1;
                    end
                    seq_len_next = usv_pkg::SEQ_NONE;
                    acc_next     = '0;
                end
            end

            if (head_item.last)
            begin
                res_valid_next = 1'b1;
                pending_next   = '0;
                seq_len_next   = usv_pkg::SEQ_NONE;
                acc_next       = '0;
                err_next       = 1'b0;
                seen_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            seq_len_reg   <= usv_pkg::SEQ_NONE;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            seq_len_reg   <= seq_len_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, loaded when a last byte is decoded
    always_ff @(posedge clk)
    begin
        if (pop && head_item.last)
        begin
            res_ok_reg    <= !(err_next_pre_clear(err_reg, head_item, pending_reg,
                                                  count_inc, max_bytes, cp_bad));
            res_count_reg <= (count_inc > {1'b0, max_bytes}) ? max_bytes
                                 : count_inc[usv_pkg::COUNT_W-1:0];
        end
    end

    assign res_valid      = res_valid_reg;
    assign res_is_valid   = res_ok_reg;
    assign res_byte_count = res_count_reg;

endmodule

// ----- design/utf8_stream_validator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_top: streaming utf-8 string checker
// checks one byte per word for well-formed utf-8 and gives verdict and length
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] data_byte, s_tlast last_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata[0] is_valid, [21:1] byte_count
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
//  one byte per clock while no verdict waits in a full output slot; the
//  classifier writes a small queue, the decoder reads its registered head
//  and registers the verdict in the result slot that drives m_
//  a full output slot stalls only the decoder on a last byte; the queue keeps
//  taking bytes until it fills: s_tready drops once it holds QUEUE_DEPTH words
//  reset is asynchronous and clears all string state at once, no clearing pass
//  cfg_ready is always high; writes to unknown indexes are dropped
// ----------------------------------------------------------------------------
module utf8_stream_validator_top
#(
    parameter int unsigned QUEUE_DEPTH = usv_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [usv_pkg::DATA_W-1:0]          s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // last_byte
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [usv_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [0] is_valid, [21:1] byte_count
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [usv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [usv_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [usv_pkg::COUNT_W-1:0] max_bytes_reg;
    logic                        reject_nul_reg;

    usv_pkg::item_t              front_item;
    usv_pkg::item_t              head_item;
    logic                        queue_full;
    logic                        head_valid;
    logic                        back_pop;
    logic                        res_is_valid;
    logic [usv_pkg::COUNT_W-1:0] res_byte_count;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg  <= usv_pkg::MAX_BYTES_RST;
            reject_nul_reg <= usv_pkg::REJECT_NUL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                usv_pkg::REG_MAX_BYTES:  max_bytes_reg  <= cfg_data;
                usv_pkg::REG_REJECT_NUL: reject_nul_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // input side takes a word whenever the queue has room
    assign s_tready = !queue_full;

    usv_front u_front
    (
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .reject_nul (reject_nul_reg),
        .item       (front_item)
    );

    usv_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (back_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    usv_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (back_pop),
        .max_bytes      (max_bytes_reg),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res_is_valid   (res_is_valid),
        .res_byte_count (res_byte_count)
    );

    // pack result word, zero fill to whole bytes
    assign m_tdata = {{(usv_pkg::OUT_TDATA_W - usv_pkg::COUNT_W - 1){1'b0}},
                      res_byte_count, res_is_valid};

endmodule
